// File: design/pcn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_pkg
// Shared types and constants of the path component normalizer.
// ----------------------------------------------------------------------------
package pcn_pkg;

  // fixed field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned DIR_LEN_W = 7;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  // length of the root directory "./" with its terminator
  localparam int unsigned ROOT_LEN = 3;

  // input operation codes
  typedef enum logic {
    OP_PATH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // result kinds
  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  // where the read data of a read result comes from
  typedef enum logic [1:0] {
    RD_ZERO  = 2'd0,
    RD_DOT   = 2'd1,
    RD_SLASH = 2'd2,
    RD_MEM   = 2'd3
  } rd_src_e;

  // result of one accepted item, apart from the memory read data
  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic [DIR_LEN_W-1:0] dir_len;
    logic                 overflow;
    rd_src_e              rd_src;
  } res_t;

endpackage
`default_nettype wire

// File: design/pcn_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_in_if
// Input channel: operation, path byte and read position.
// ----------------------------------------------------------------------------
interface pcn_in_if import pcn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [CHAR_W-1:0] path_char;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, output operation, output path_char, output read_index,
                  input ready);
  modport sink   (input valid, input operation, input path_char, input read_index,
                  output ready);
endinterface
`default_nettype wire

// File: design/pcn_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_out_if
// Result channel: length report or stored directory byte.
// ----------------------------------------------------------------------------
interface pcn_out_if import pcn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  logic [DIR_LEN_W-1:0] dir_len;
  logic                 overflow;
  logic [CHAR_W-1:0]    read_data;

  modport source (output valid, output result_kind, output dir_len, output overflow,
                  output read_data, input ready);
  modport sink   (input valid, input result_kind, input dir_len, input overflow,
                  input read_data, output ready);
endinterface
`default_nettype wire

// File: design/pcn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pcn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/pcn_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_walker
// Directory state, component tracking, directory store and separator stack.
// ----------------------------------------------------------------------------
module pcn_walker import pcn_pkg::*; #(
  parameter int unsigned BUF_BYTES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              operation_i,
  input  wire logic [CHAR_W-1:0] path_char_i,
  input  wire logic [IDX_W-1:0]  read_index_i,
  output res_t                   res_o,
  output logic      [CHAR_W-1:0] rdata_o
);

  localparam int unsigned AW    = $clog2(BUF_BYTES);
  localparam int unsigned LW    = $clog2(BUF_BYTES + 1);
  localparam int unsigned LW1   = LW + 1;
  localparam int unsigned DEPTH = BUF_BYTES / 2;
  localparam int unsigned TW    = $clog2(DEPTH);
  localparam int unsigned TW1   = TW + 1;
  localparam int unsigned CW    = ((LW > IDX_W) ? LW : IDX_W) + 1;

  localparam logic [LW-1:0]  ROOT_L   = LW'(ROOT_LEN);
  localparam logic [LW-1:0]  ROOT_M1  = LW'(ROOT_LEN - 1);
  localparam logic [LW-1:0]  BUF_L    = LW'(BUF_BYTES);
  localparam logic [LW1-1:0] BUF_W    = LW1'(BUF_BYTES);
  localparam logic [TW1-1:0] DEPTH_W  = TW1'(DEPTH);

  // state
  logic [LW-1:0] dir_len_q, dir_len_d;
  logic [TW-1:0] top_q, top_d;
  logic [LW-1:0] clen_q, clen_d;
  logic [1:0]    dots_q, dots_d;
  logic          start_q, start_d;
  logic          err_q, err_d;

  // memory ports
  logic              dir_we;
  logic [AW-1:0]     dir_waddr;
  logic [CHAR_W-1:0] dir_wdata;
  logic              dir_re;
  logic              stk_we;
  logic [TW-1:0]     stk_waddr;
  logic [AW-1:0]     stk_wdata;
  logic [AW-1:0]     stk_rdata;

  // helpers
  logic          is_sep;
  logic          go_root;
  logic          is_dot1;
  logic          is_dot2;
  logic [AW-1:0] sep_pos;
  logic [LW1-1:0] sum;
  logic [LW1-1:0] pos;
  logic [LW-1:0] base;
  logic          rd_ok;

  assign is_sep  = (path_char_i == CH_SLASH) || (path_char_i == CH_NUL);
  assign go_root = start_q && (path_char_i == CH_SLASH);
  assign is_dot1 = (clen_q == LW'(1)) && dots_q[0];
  assign is_dot2 = (clen_q == LW'(2)) && (&dots_q);
  // bottom of the stack is always the root separator
  assign sep_pos = (top_q == '0) ? AW'(1) : stk_rdata;
  assign sum     = LW1'(dir_len_q) + LW1'(clen_q);
  assign base    = (dir_len_q > ROOT_L) ? dir_len_q : ROOT_M1;
  assign pos     = LW1'(base) + LW1'(clen_q);
  assign rd_ok   = ((CW'(read_index_i) + CW'(1)) < CW'(dir_len_q)) &&
                   (CW'(read_index_i) < CW'(BUF_BYTES));
  assign dir_re  = accept_i && (operation_i == OP_READ);

  // next state and result of the accepted item
  always_comb begin
    dir_len_d = dir_len_q;
    top_d     = top_q;
    clen_d    = clen_q;
    dots_d    = dots_q;
    start_d   = start_q;
    err_d     = err_q;
    dir_we    = 1'b0;
    dir_waddr = '0;
    dir_wdata = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    res_o          = '0;
    res_o.kind     = KIND_REPORT;
    res_o.rd_src   = RD_ZERO;

    if (accept_i && (operation_i == OP_READ)) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_READ;
      if (!rd_ok) begin
        res_o.rd_src = RD_ZERO;
      end else if (read_index_i == IDX_W'(0)) begin
        res_o.rd_src = RD_DOT;
      end else if (read_index_i == IDX_W'(1)) begin
        res_o.rd_src = RD_SLASH;
      end else begin
        res_o.rd_src = RD_MEM;
      end
    end else if (accept_i) begin
      start_d = 1'b0;
      if (go_root) begin
        // leading slash: back to the root
        dir_len_d = ROOT_L;
        top_d     = '0;
        clen_d    = '0;
        dots_d    = '0;
      end else if (is_sep) begin
        // close the component in progress
        clen_d = '0;
        dots_d = '0;
        if ((clen_q != '0) && !err_q && !is_dot1) begin
          if (is_dot2) begin
            // parent: drop back to the previous separator
            if (top_q != '0) begin
              top_d = top_q - TW'(1);
            end
            dir_len_d = (sep_pos <= AW'(1)) ? ROOT_L : (LW'(sep_pos) + LW'(1));
          end else if (sum >= BUF_W) begin
            err_d = 1'b1;
          end else if (dir_len_q > ROOT_L) begin
            dir_we    = 1'b1;
            dir_waddr = AW'(dir_len_q - LW'(1));
            dir_wdata = CH_SLASH;
            if ((TW1'(top_q) + TW1'(1)) < DEPTH_W) begin
              top_d     = top_q + TW'(1);
              stk_we    = 1'b1;
              stk_waddr = top_q + TW'(1);
              stk_wdata = AW'(dir_len_q - LW'(1));
            end
            dir_len_d = LW'(sum + LW1'(1));
          end else begin
            dir_len_d = LW'(sum);
          end
        end
        // terminator: report and rearm for the next path
        if (path_char_i == CH_NUL) begin
          res_o.valid    = 1'b1;
          res_o.kind     = KIND_REPORT;
          res_o.dir_len  = DIR_LEN_W'(dir_len_d);
          res_o.overflow = err_d;
          start_d        = 1'b1;
          err_d          = 1'b0;
        end
      end else if (!err_q) begin
        // ordinary byte: park it at its final place
        if (pos < BUF_W) begin
          dir_we    = 1'b1;
          dir_waddr = AW'(pos);
          dir_wdata = path_char_i;
        end
        if ((path_char_i == CH_DOT) && (clen_q < LW'(2))) begin
          dots_d[clen_q[0]] = 1'b1;
        end
        if (clen_q < BUF_L) begin
          clen_d = clen_q + LW'(1);
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_len_q <= ROOT_L;
      top_q     <= '0;
      clen_q    <= '0;
      dots_q    <= '0;
      start_q   <= 1'b1;
      err_q     <= 1'b0;
    end else begin
      dir_len_q <= dir_len_d;
      top_q     <= top_d;
      clen_q    <= clen_d;
      dots_q    <= dots_d;
      start_q   <= start_d;
      err_q     <= err_d;
    end
  end

  // directory bytes
  pcn_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_BYTES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (dir_re),
    .raddr_i (AW'(read_index_i)),
    .rdata_o (rdata_o)
  );

  // separator positions, top entry read every cycle
  pcn_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (1'b1),
    .raddr_i (top_q),
    .rdata_o (stk_rdata)
  );

endmodule
`default_nettype wire

// File: design/path_component_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// path_component_normalizer
// Applies paths, one byte per transfer, to a stored working directory and
// serves reads of the stored directory bytes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | results
//  in_i    | in  | operation, path_char, read_index          | -
//  out_o   | out | result_kind, dir_len, overflow, read_data | terminator, read
//
//  One input transfer per cycle while in_i.ready is high; a result passes the
//  walker stage with the registered memory read, then the output register.
//  A parent component pops the separator stack; the stack top is prefetched
//  from its memory every cycle.
//  Reset restores the root directory "./" at once, no clearing pass.
//  in_i.ready drops only while both the stage register and the output
//  register hold results and out_o.ready is low.
// ----------------------------------------------------------------------------
module path_component_normalizer import pcn_pkg::*; #(
  parameter int unsigned BUF_BYTES = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pcn_in_if.sink     in_i,
  pcn_out_if.source  out_o
);

  logic              accept;
  logic              s1_move;
  res_t              res;
  logic [CHAR_W-1:0] rdata;

  logic              s1_valid_q, s1_valid_d;
  res_t              s1_res_q;
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q;
  logic [DIR_LEN_W-1:0] out_dir_len_q;
  logic              out_ovf_q;
  logic [CHAR_W-1:0] out_data_q;
  logic [CHAR_W-1:0] s1_data;

  // handshake
  assign s1_move    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_move;
  assign accept     = in_i.valid && in_i.ready;

  pcn_walker #(
    .BUF_BYTES (BUF_BYTES)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (in_i.operation),
    .path_char_i  (in_i.path_char),
    .read_index_i (in_i.read_index),
    .res_o        (res),
    .rdata_o      (rdata)
  );

  // read data selection
  always_comb begin
    unique case (s1_res_q.rd_src)
      RD_ZERO:  s1_data = '0;
      RD_DOT:   s1_data = CH_DOT;
      RD_SLASH: s1_data = CH_SLASH;
      RD_MEM:   s1_data = rdata;
      default:  s1_data = '0;
    endcase
  end

  // stage and output valid
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (accept) begin
      s1_valid_d = res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      out_kind_q    <= s1_res_q.kind;
      out_dir_len_q <= s1_res_q.dir_len;
      out_ovf_q     <= s1_res_q.overflow;
      out_data_q    <= s1_data;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.dir_len     = out_dir_len_q;
  assign out_o.overflow    = out_ovf_q;
  assign out_o.read_data   = out_data_q;

  // checks
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_res_q))
    else $error("stalled stage result changed");

  a_report_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.result_kind == KIND_REPORT) |-> out_o.read_data == '0)
    else $error("report carries read data");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.result_kind == KIND_READ) |->
      (out_o.dir_len == '0) && !out_o.overflow)
    else $error("read result carries report fields");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free result slot");

endmodule
`default_nettype wire

// File: test/path_normalizer_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// path_normalizer_checker
// Watches both channels of the path component normalizer, keeps its own
// copy of the working directory and the separator stack, predicts the
// report or read byte of every accepted terminator or read and compares the results.
// ----------------------------------------------------------------------------
module path_normalizer_checker import pcn_pkg::*; #(
  parameter int unsigned BUF_BYTES = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic                 in_operation_i,
  input  wire logic [CHAR_W-1:0]    in_path_char_i,
  input  wire logic [IDX_W-1:0]     in_read_index_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic                 out_result_kind_i,
  input  wire logic [DIR_LEN_W-1:0] out_dir_len_i,
  input  wire logic                 out_overflow_i,
  input  wire logic [CHAR_W-1:0]    out_read_data_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        reports_o,
  output int                        overflows_o,
  output int                        reads_o,
  output int                        max_depth_o
);

  localparam int unsigned SEP_DEPTH = BUF_BYTES / 2;
  localparam int unsigned SEP_W     = $clog2(SEP_DEPTH);

  typedef struct packed {
    kind_e                kind;
    logic [DIR_LEN_W-1:0] dir_len;
    logic                 overflow;
    logic [CHAR_W-1:0]    read_data;
  } dir_result_t;

  // predicted directory state
  logic [CHAR_W-1:0]    dir_bytes [BUF_BYTES];
  logic [DIR_LEN_W-1:0] dir_len_q;
  logic [IDX_W-1:0]     sep_pos [SEP_DEPTH];
  logic [SEP_W-1:0]     sep_top;
  logic [DIR_LEN_W-1:0] comp_len;
  logic [1:0]           dot_flags;
  logic                 path_start;
  logic                 comp_error;

  dir_result_t awaited_dir_results [$];
  int          mismatches;

  // back to the root directory "./"
  function automatic void goto_root();
    dir_bytes[0] = CH_DOT;
    dir_bytes[1] = CH_SLASH;
    dir_bytes[2] = CH_NUL;
    dir_len_q    = DIR_LEN_W'(ROOT_LEN);
    sep_top      = '0;
    sep_pos[0]   = IDX_W'(1);
  endfunction

  function automatic void clear_directory();
    for (int k = 0; k < BUF_BYTES; k++) dir_bytes[k] = '0;
    for (int k = 0; k < SEP_DEPTH; k++) sep_pos[k] = '0;
    goto_root();
    comp_len   = '0;
    dot_flags  = '0;
    path_start = 1'b1;
    comp_error = 1'b0;
  endfunction

  // a separator or terminator closes the component in progress
  function automatic void close_component();
    int unsigned n;
    int unsigned sep;
    int unsigned len;
    logic        one_dot;
    logic        two_dot;
    n         = comp_len;
    len       = dir_len_q;
    one_dot   = dot_flags[0];
    two_dot   = dot_flags[1];
    comp_len  = '0;
    dot_flags = '0;
    if (n == 0 || comp_error) return;
    // "." is dropped
    if (n == 1 && one_dot) return;
    // ".." pops to the previous separator, never above the root
    if (n == 2 && one_dot && two_dot) begin
      sep = sep_pos[sep_top];
      if (sep_top > 0) sep_top = sep_top - 1'b1;
      dir_len_q = (sep <= 1) ? DIR_LEN_W'(ROOT_LEN) : DIR_LEN_W'(sep + 1);
      return;
    end
    // component does not fit
    if (len + n >= BUF_BYTES) begin
      comp_error = 1'b1;
      return;
    end
    if (len > ROOT_LEN) begin
      dir_bytes[len - 1] = CH_SLASH;
      if (sep_top + 1 < SEP_DEPTH) begin
        sep_top          = sep_top + 1'b1;
        sep_pos[sep_top] = IDX_W'(len - 1);
      end
      dir_len_q = DIR_LEN_W'(len + n + 1);
    end else begin
      dir_len_q = DIR_LEN_W'(ROOT_LEN + n);
    end
  endfunction

  // apply one accepted transfer; returns 1 when it produces a result
  function automatic bit apply_transfer(input logic op, input logic [CHAR_W-1:0] ch,
                                        input logic [IDX_W-1:0] idx,
                                        output dir_result_t res);
    int unsigned base;
    int unsigned pos;
    res = '0;
    if (op == OP_READ) begin
      res.kind = KIND_READ;
      if (idx + 1 < dir_len_q && idx < BUF_BYTES) res.read_data = dir_bytes[idx];
      return 1'b1;
    end
    if (path_start) begin
      path_start = 1'b0;
      if (ch == CH_SLASH) goto_root();
    end
    if (ch == CH_SLASH || ch == CH_NUL) begin
      close_component();
      if (ch == CH_SLASH) return 1'b0;
      res.kind     = KIND_REPORT;
      res.dir_len  = dir_len_q;
      res.overflow = comp_error;
      path_start   = 1'b1;
      comp_error   = 1'b0;
      comp_len     = '0;
      dot_flags    = '0;
      return 1'b1;
    end
    if (comp_error) return 1'b0;
    // pending byte goes to its final place beyond the visible length
    base = (dir_len_q > ROOT_LEN) ? dir_len_q : ROOT_LEN - 1;
    pos  = base + comp_len;
    if (pos < BUF_BYTES) dir_bytes[pos] = ch;
    if (ch == CH_DOT && comp_len < 2) dot_flags[comp_len[0]] = 1'b1;
    if (comp_len < BUF_BYTES) comp_len = comp_len + 1'b1;
    return 1'b0;
  endfunction

  // compare results, then predict from the accepted input
  always @(posedge clk_i or negedge rst_ni) begin
    dir_result_t want;
    dir_result_t got;
    if (!rst_ni) begin
      clear_directory();
      awaited_dir_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      reports_o    <= 0;
      overflows_o  <= 0;
      reads_o      <= 0;
      max_depth_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.kind      = kind_e'(out_result_kind_i);
        got.dir_len   = out_dir_len_i;
        got.overflow  = out_overflow_i;
        got.read_data = out_read_data_i;
        if (awaited_dir_results.size() == 0) begin
          $display("%0t: result transfer with nothing awaited, kind %0b len %0d ovf %0b data %0h",
                   $time, out_result_kind_i, out_dir_len_i, out_overflow_i, out_read_data_i);
          mismatches++;
        end else begin
          want = awaited_dir_results.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: result_kind mismatch, expected %0b, got %0b",
                     $time, want.kind, out_result_kind_i);
            mismatches++;
          end
          if (got.dir_len !== want.dir_len) begin
            $display("%0t: dir_len mismatch, expected %0d, got %0d",
                     $time, want.dir_len, out_dir_len_i);
            mismatches++;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, got %0b",
                     $time, want.overflow, out_overflow_i);
            mismatches++;
          end
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %0h, got %0h",
                     $time, want.read_data, out_read_data_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (apply_transfer(in_operation_i, in_path_char_i, in_read_index_i, want)) begin
          awaited_dir_results.push_back(want);
          if (want.kind == KIND_READ) reads_o <= reads_o + 1;
          else begin
            reports_o <= reports_o + 1;
            if (want.overflow) overflows_o <= overflows_o + 1;
          end
        end
        if (int'(sep_top) > max_depth_o) max_depth_o <= int'(sep_top);
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_dir_results.size();
    end
  end

endmodule
`default_nettype wire

// File: test/path_component_normalizer_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// path_component_normalizer_tb
// Feeds paths and directory reads to the path component normalizer: a few
// directed paths for root, parent, dot and odd bytes, then random relative
// and absolute paths with noise, under sender gaps, receiver stalls and one
// long receiver hold. Results are checked by the checker beside the block.
// ----------------------------------------------------------------------------
module path_component_normalizer_tb;
  import pcn_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 390;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned PRESSURE_READS  = 40;
  localparam int unsigned DRAIN_CYCLES    = 10;

  logic clk_i;
  logic rst_ni;

  pcn_in_if  in_bus ();
  pcn_out_if out_bus ();

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_seq;
  int unsigned items_sent;
  logic [CHAR_W-1:0] path_q [$];

  int fail_count;
  int pending;
  int reports;
  int overflows;
  int reads;
  int max_depth;

  path_component_normalizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  path_normalizer_checker chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_bus.valid),
    .in_ready_i        (in_bus.ready),
    .in_operation_i    (in_bus.operation),
    .in_path_char_i    (in_bus.path_char),
    .in_read_index_i   (in_bus.read_index),
    .out_valid_i       (out_bus.valid),
    .out_ready_i       (out_bus.ready),
    .out_result_kind_i (out_bus.result_kind),
    .out_dir_len_i     (out_bus.dir_len),
    .out_overflow_i    (out_bus.overflow),
    .out_read_data_i   (out_bus.read_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .reports_o         (reports),
    .overflows_o       (overflows),
    .reads_o           (reads),
    .max_depth_o       (max_depth)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d results still awaited", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls, plus a long hold on request
  initial begin
    int unsigned hold_seen;
    hold_seen     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // one transfer on the input channel, with random sender gaps before it
  task automatic send_item(input op_e op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.path_char  <= ch;
    in_bus.read_index <= idx;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // unused fields carry random values
  task automatic send_byte(input logic [CHAR_W-1:0] ch);
    send_item(OP_PATH, ch, IDX_W'($urandom_range(0, 63)));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(CHAR_W'(s[k]));
  endtask

  // mostly lower-case letters, sometimes any byte except slash and terminator
  function automatic logic [CHAR_W-1:0] name_char();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(99) < 70) return CHAR_W'($urandom_range(8'h61, 8'h7A));
    c = CHAR_W'($urandom_range(1, 255));
    if (c == CH_SLASH) c = CH_DOT;
    return c;
  endfunction

  // build one random path into path_q, terminator included
  task automatic make_path();
    int unsigned n_comp;
    int unsigned pick;
    int unsigned len;
    path_q.delete();
    // noise: raw bytes, may hold early terminators and slashes
    if ($urandom_range(99) < 8) begin
      len = $urandom_range(1, 8);
      repeat (len) path_q.push_back(CHAR_W'($urandom_range(0, 255)));
      path_q.push_back(CH_NUL);
      return;
    end
    if ($urandom_range(99) < 20) path_q.push_back(CH_SLASH);
    n_comp = $urandom_range(0, 6);
    for (int c = 0; c < n_comp; c++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        path_q.push_back(CH_DOT);
        path_q.push_back(CH_DOT);
      end else if (pick < 30) begin
        path_q.push_back(CH_DOT);
      end else if (pick < 34) begin
        // long name, often too big for what is left
        len = $urandom_range(15, 62);
        repeat (len) path_q.push_back(name_char());
      end else if (pick < 40) begin
        // names that look like dot components, some of them a real parent
        path_q.push_back(CH_DOT);
        if ($urandom_range(1)) path_q.push_back(CH_DOT);
        path_q.push_back($urandom_range(1) ? CH_DOT : name_char());
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) path_q.push_back(name_char());
      end
      if (c + 1 < n_comp || $urandom_range(99) < 15) begin
        len = ($urandom_range(99) < 80) ? 1 : $urandom_range(2, 3);
        repeat (len) path_q.push_back(CH_SLASH);
      end
    end
    path_q.push_back(CH_NUL);
  endtask

  // random paths with reads mixed in between the bytes
  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned start;
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    start          = items_sent;
    while (items_sent - start < ITEMS_PER_PHASE) begin
      make_path();
      foreach (path_q[k]) begin
        if ($urandom_range(99) < 12) begin
          if ($urandom_range(1)) send_read(IDX_W'($urandom_range(0, 15)));
          else send_read(IDX_W'($urandom_range(0, 63)));
        end
        send_byte(path_q[k]);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    in_bus.valid      = 1'b0;
    in_bus.operation  = OP_PATH;
    in_bus.path_char  = '0;
    in_bus.read_index = '0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    hold_seq          = 0;
    items_sent        = 0;
    rst_ni            = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: root bytes and the top read index
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(63));
    // name at the root, then parent back to the root
    send_text("ab");
    send_byte(CH_NUL);
    send_text("..");
    send_byte(CH_NUL);
    // absolute path, merged slashes, dropped dot
    send_text("/x//.");
    send_byte(CH_NUL);
    // high byte as a name, read back under a separator
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_read(IDX_W'(4));
    // three dots are an ordinary name
    send_text("...");
    send_byte(CH_NUL);
    // empty path
    send_byte(CH_NUL);
    send_text("..");
    send_byte(CH_NUL);

    // random phases
    run_phase(0, 0);
    run_phase(70, 0);
    run_phase(0, 70);
    run_phase(22, 22);

    // receiver holds off while the sender keeps offering reads
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_seq++;
    repeat (PRESSURE_READS) send_read(IDX_W'($urandom_range(0, 63)));
    run_phase(0, 0);

    in_bus.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input transfers: %0d path reports (%0d overflowed), %0d reads",
             items_sent, reports, overflows, reads);
    $display("separator stack reached depth %0d; gaps, stalls and a %0d-cycle hold applied",
             max_depth, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
